@@ hw/rtl/pcs_pkg.sv @@
// ----------------------------------------------------------------------------
// pcs_pkg: shared types and constants
// Field widths, command codes and controller states for the polynomial
// coefficient store.
// ----------------------------------------------------------------------------
package pcs_pkg;

  // Fixed field widths of the command and result channels.
  localparam int DATA_W  = 32;
  localparam int INDEX_W = 16;
  localparam int CMD_W   = 2;
  localparam int DEG_W   = 6;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_SET  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SUB  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_EVAL = 2'd3;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY,
    ST_SCAN,
    ST_EVAL_START,
    ST_EVAL_MUL,
    ST_EVAL_ADD
  } pcs_state_t;

endpackage

@@ hw/rtl/pcs_coeff_ram.sv @@
// ----------------------------------------------------------------------------
// pcs_coeff_ram: coefficient memory
// Simple dual-port synchronous memory, one write port and one read port,
// with the read data registered.
// ----------------------------------------------------------------------------
module pcs_coeff_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/polynomial_coefficient_store_unit.sv @@
// ----------------------------------------------------------------------------
// polynomial_coefficient_store_unit: integer polynomial store and evaluator
// Holds TERMS signed 32-bit coefficients in one memory, tracks the degree,
// applies set/add/subtract commands and evaluates by Horner's rule.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfer happens at a clock edge with start high and busy low.
//   in_cmd selects set, add, subtract or evaluate; in_index picks the power
//   of x, in_coeff_in is the written amount and in_point is x for evaluate.
//   Every command gives exactly one result, shown for one cycle with
//   out_valid high. The receiver cannot stall; results are never held.
// Sequence (from the command transfer to the result):
//   write beyond the store: the result is registered directly from idle.
//   set/add/subtract: the entry is read at the transfer and written back in
//     the modify state; when the top coefficient is cleared, a scan then
//     walks downward one coefficient at a time through the single read port.
//   evaluate: a start state, then for each Horner step a multiply state and
//     an add state that also receives the memory read.
//   busy drops in the result cycle, so a new command can follow at once.
// Reset: rst_n low clears the control state; afterwards a clearing pass
//   writes zero to all TERMS entries, one per cycle, with busy held high.
// ----------------------------------------------------------------------------
module polynomial_coefficient_store_unit #(
  parameter int TERMS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [pcs_pkg::CMD_W-1:0]           in_cmd,
  input  logic [pcs_pkg::INDEX_W-1:0]         in_index,
  input  logic signed [pcs_pkg::DATA_W-1:0]   in_coeff_in,
  input  logic signed [pcs_pkg::DATA_W-1:0]   in_point,
  output logic                                out_valid,
  output logic signed [pcs_pkg::DATA_W-1:0]   out_value,
  output logic signed [pcs_pkg::DATA_W-1:0]   out_coeff_out,
  output logic [pcs_pkg::DEG_W-1:0]           out_degree_out,
  output logic                                out_overflow
);

  import pcs_pkg::*;

  localparam int AW = $clog2(TERMS);
  localparam logic [AW-1:0] LAST = AW'(TERMS - 1);

  // Registers and their next values.
  pcs_state_t        state_r,     state_nxt;
  logic [CMD_W-1:0]  cmd_r,       cmd_nxt;
  logic [AW-1:0]     idx_r,       idx_nxt;
  logic              inside_r,    inside_nxt;
  logic [DATA_W-1:0] coeff_r,     coeff_nxt;
  logic [DATA_W-1:0] point_r,     point_nxt;
  logic [DATA_W-1:0] acc_r,       acc_nxt;
  logic [DATA_W-1:0] prod_r,      prod_nxt;
  logic [AW-1:0]     ptr_r,       ptr_nxt;
  logic [AW-1:0]     deg_r,       deg_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic [DATA_W-1:0] out_coeff_r, out_coeff_nxt;
  logic [DEG_W-1:0]  out_deg_r,   out_deg_nxt;
  logic              out_ovf_r,   out_ovf_nxt;

  // Memory port signals.
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  // Datapath helpers.
  logic              in_inside;
  logic [DATA_W-1:0] new_coeff;
  logic [DATA_W-1:0] horner_sum;

  pcs_coeff_ram #(
    .DEPTH (TERMS),
    .WIDTH (DATA_W),
    .AW    (AW)
  ) u_coeff_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign in_inside = (in_index < INDEX_W'(TERMS));

  // Read-modify-write result for the stored command.
  always_comb begin
    case (cmd_r)
      CMD_SET: new_coeff = coeff_r;
      CMD_ADD: new_coeff = mem_rdata + coeff_r;
      CMD_SUB: new_coeff = mem_rdata - coeff_r;
      default: new_coeff = mem_rdata;
    endcase
  end

  // Horner add step: registered product plus the coefficient just read.
  assign horner_sum = prod_r + mem_rdata;

  // Next state, memory control and result formation.
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    inside_nxt    = inside_r;
    coeff_nxt     = coeff_r;
    point_nxt     = point_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    ptr_nxt       = ptr_r;
    deg_nxt       = deg_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    out_coeff_nxt = out_coeff_r;
    out_deg_nxt   = out_deg_r;
    out_ovf_nxt   = out_ovf_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = new_coeff;
    mem_raddr     = in_index[AW-1:0];

    case (state_r)
      // Zero every entry after reset.
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = '0;
        if (ptr_r == LAST) begin
          ptr_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end

      // Take a command; the read of its entry starts in this cycle.
      ST_IDLE: begin
        if (start) begin
          cmd_nxt    = in_cmd;
          idx_nxt    = in_index[AW-1:0];
          inside_nxt = in_inside;
          coeff_nxt  = in_coeff_in;
          point_nxt  = in_point;
          if (in_cmd == CMD_EVAL) begin
            state_nxt = ST_EVAL_START;
          end else if (!in_inside) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = '0;
            out_coeff_nxt = '0;
            out_deg_nxt   = DEG_W'(deg_r);
            out_ovf_nxt   = (in_coeff_in != '0);
          end else begin
            state_nxt = ST_MODIFY;
          end
        end
      end

      // Write back the updated coefficient and adjust the degree.
      ST_MODIFY: begin
        mem_we        = 1'b1;
        out_value_nxt = '0;
        out_coeff_nxt = new_coeff;
        out_ovf_nxt   = 1'b0;
        if ((new_coeff != '0) && (idx_r > deg_r)) begin
          deg_nxt       = idx_r;
          out_deg_nxt   = DEG_W'(idx_r);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if ((new_coeff == '0) && (idx_r == deg_r) && (idx_r != '0)) begin
          ptr_nxt   = idx_r - AW'(1);
          mem_raddr = idx_r - AW'(1);
          state_nxt = ST_SCAN;
        end else begin
          out_deg_nxt   = DEG_W'(deg_r);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      // Walk downward until a nonzero coefficient or index zero is found.
      ST_SCAN: begin
        if ((mem_rdata != '0) || (ptr_r == '0)) begin
          deg_nxt       = ptr_r;
          out_deg_nxt   = DEG_W'(ptr_r);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          ptr_nxt   = ptr_r - AW'(1);
          mem_raddr = ptr_r - AW'(1);
        end
      end

      // Capture the addressed coefficient and set up the Horner walk.
      ST_EVAL_START: begin
        out_coeff_nxt = inside_r ? mem_rdata : '0;
        acc_nxt       = '0;
        ptr_nxt       = deg_r;
        state_nxt     = ST_EVAL_MUL;
      end

      // Multiply the accumulator by x while the next coefficient is read.
      ST_EVAL_MUL: begin
        prod_nxt  = acc_r * point_r;
        mem_raddr = ptr_r;
        state_nxt = ST_EVAL_ADD;
      end

      // Add the coefficient; finish after the constant term.
      ST_EVAL_ADD: begin
        acc_nxt = horner_sum;
        if (ptr_r == '0) begin
          out_value_nxt = horner_sum;
          out_deg_nxt   = DEG_W'(deg_r);
          out_ovf_nxt   = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          ptr_nxt   = ptr_r - AW'(1);
          state_nxt = ST_EVAL_MUL;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ptr_r       <= '0;
      deg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      deg_r       <= deg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    idx_r       <= idx_nxt;
    inside_r    <= inside_nxt;
    coeff_r     <= coeff_nxt;
    point_r     <= point_nxt;
    acc_r       <= acc_nxt;
    prod_r      <= prod_nxt;
    out_value_r <= out_value_nxt;
    out_coeff_r <= out_coeff_nxt;
    out_deg_r   <= out_deg_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_coeff_out  = out_coeff_r;
  assign out_degree_out = out_deg_r;
  assign out_overflow   = out_ovf_r;

endmodule

@@ verif/tb_polynomial_coefficient_store_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polynomial_coefficient_store_unit: self-checking bench for the store
// Sends set, add, subtract and evaluate commands: directed corners first,
// then random polynomial traffic under three sender idle profiles. The
// bench keeps its own copy of the coefficients and degree, predicts every
// result from it (evaluate by Horner's rule), and checks each result transfer in order.
// ----------------------------------------------------------------------------
module tb_polynomial_coefficient_store_unit;
  import pcs_pkg::*;

  localparam int TERMS       = 64;
  localparam int IDX_AW      = $clog2(TERMS);
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 2 * TERMS + 8;
  localparam int MAX_REPORTS = 10;

  typedef logic [DATA_W-1:0]  word_t;
  typedef logic [CMD_W-1:0]   cmd_t;
  typedef logic [INDEX_W-1:0] index_t;

  typedef struct packed {
    word_t              value;
    word_t              coeff;
    logic [DEG_W-1:0]   degree;
    logic               overflow;
  } poly_outcome_t;

  logic                      clk         = 1'b0;
  logic                      rst_n       = 1'b0;
  logic                      start       = 1'b0;
  cmd_t                      in_cmd      = CMD_SET;
  index_t                    in_index    = '0;
  logic signed [DATA_W-1:0]  in_coeff_in = '0;
  logic signed [DATA_W-1:0]  in_point    = '0;
  logic                      busy;
  logic                      out_valid;
  logic signed [DATA_W-1:0]  out_value;
  logic signed [DATA_W-1:0]  out_coeff_out;
  logic [DEG_W-1:0]          out_degree_out;
  logic                      out_overflow;

  // Bench copy of the polynomial and the results still owed by the block.
  word_t           poly_coef [TERMS] = '{default: '0};
  int unsigned     poly_degree = 0;
  poly_outcome_t   poly_outcomes [$];

  int idle_pct       = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int fail_count     = 0;
  int report_count   = 0;
  int stall_cycles   = 0;
  int overflow_hits  = 0;
  int degree_drops   = 0;
  int max_degree     = 0;
  int cmd_counts [4] = '{default: 0};
  int idle_plan [3]  = '{32, 50, 0};

  polynomial_coefficient_store_unit #(
    .TERMS(TERMS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_index      (in_index),
    .in_coeff_in   (in_coeff_in),
    .in_point      (in_point),
    .out_valid     (out_valid),
    .out_value     (out_value),
    .out_coeff_out (out_coeff_out),
    .out_degree_out(out_degree_out),
    .out_overflow  (out_overflow)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Horner's rule over the bench copy; every product and sum wraps at 32 bits.
  function automatic word_t horner_eval(word_t x);
    word_t acc;
    acc = '0;
    for (int k = poly_degree; k >= 0; k--) begin
      acc = acc * x + poly_coef[k];
    end
    return acc;
  endfunction

  // Applies one command to the bench copy and returns the result it should give.
  function automatic poly_outcome_t apply_poly_cmd(cmd_t cmd, index_t idx, word_t c, word_t x);
    poly_outcome_t     res;
    logic              fits;
    logic [IDX_AW-1:0] slot;
    int unsigned       prev_degree;
    res = '0;
    fits = (idx < TERMS);
    slot = idx[IDX_AW-1:0];
    prev_degree = poly_degree;
    if (cmd == CMD_EVAL) begin
      res.value = horner_eval(x);
    end else if (!fits) begin
      res.overflow = (c != '0);
    end else begin
      case (cmd)
        CMD_SET: poly_coef[slot] = c;
        CMD_ADD: poly_coef[slot] = poly_coef[slot] + c;
        default: poly_coef[slot] = poly_coef[slot] - c;
      endcase
      poly_degree = 0;
      for (int k = TERMS - 1; k > 0; k--) begin
        if (poly_coef[k] != '0) begin
          poly_degree = k;
          break;
        end
      end
      if (poly_degree < prev_degree) degree_drops++;
    end
    res.coeff = fits ? poly_coef[slot] : '0;
    res.degree = poly_degree[DEG_W-1:0];
    return res;
  endfunction

  // Random command; writes_only leaves evaluate out.
  function automatic cmd_t pick_cmd(bit writes_only);
    case ($urandom_range(writes_only ? 2 : 3))
      0:       return CMD_SET;
      1:       return CMD_ADD;
      2:       return CMD_SUB;
      default: return CMD_EVAL;
    endcase
  endfunction

  // Random word biased toward the signed extremes, zero and small values.
  function automatic word_t rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'd1;
      5:       return word_t'($urandom_range(20)) - 32'd10;
      default: return $urandom;
    endcase
  endfunction

  // Result check and prediction. Inputs move on the falling edge, so the
  // values seen here are stable; the block updates its outputs after this.
  always @(posedge clk) begin : transfer_monitor
    poly_outcome_t got;
    poly_outcome_t want;
    if (rst_n) begin
      stall_cycles++;
      if (out_valid === 1'b1) begin
        stall_cycles = 0;
        got = '{out_value, out_coeff_out, out_degree_out, out_overflow};
        if (poly_outcomes.size() == 0) begin
          fail_count++;
          if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("%0t: result transfer with no command outstanding: %p", $realtime, got);
          end
        end else begin
          want = poly_outcomes.pop_front();
          results_seen++;
          if (got.value !== want.value || got.coeff !== want.coeff ||
              got.degree !== want.degree || got.overflow !== want.overflow) begin
            fail_count++;
            if (report_count < MAX_REPORTS) begin
              report_count++;
              $display("%0t: result %0d mismatch: value %h/%h coeff %h/%h degree %0d/%0d ovf %b/%b",
                       $realtime, results_seen, want.value, got.value, want.coeff, got.coeff,
                       want.degree, got.degree, want.overflow, got.overflow);
            end
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        stall_cycles = 0;
        poly_outcomes.push_back(apply_poly_cmd(in_cmd, in_index, in_coeff_in, in_point));
        cmd_counts[in_cmd]++;
        if (in_cmd != CMD_EVAL && in_index >= TERMS && in_coeff_in != 0) overflow_hits++;
        if (poly_degree > max_degree) max_degree = poly_degree;
      end
    end
  end

  // Ends the run when nothing has moved for too long.
  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(negedge clk);
    $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Sends one command and returns at the falling edge after its transfer.
  // Called at a falling edge; start stays high unless an idle gap follows.
  task automatic send_item(cmd_t cmd, index_t idx, word_t c, word_t x);
    in_cmd = cmd;
    in_index = idx;
    in_coeff_in = c;
    in_point = x;
    start = 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      in_cmd = pick_cmd(1'b0);
      in_index = index_t'($urandom);
      in_coeff_in = $urandom;
      in_point = $urandom;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // Extremes of every field, each command, wrap-around, degree drops on
  // clearing the top coefficient, and writes beyond the store.
  task automatic test_directed_corners();
    send_item(CMD_EVAL, 16'd0, 32'd0, 32'd5);
    send_item(CMD_SET, 16'd0, 32'h7FFF_FFFF, 32'd0);
    send_item(CMD_ADD, 16'd0, 32'd1, 32'd0);
    send_item(CMD_SUB, 16'd0, 32'h8000_0000, 32'd0);
    send_item(CMD_SET, index_t'(TERMS - 1), 32'h8000_0000, 32'd0);
    send_item(CMD_SET, 16'd1, 32'hFFFF_FFFF, 32'd0);
    send_item(CMD_SET, 16'd0, 32'd7, 32'd0);
    send_item(CMD_EVAL, 16'd0, 32'd0, 32'd1);
    send_item(CMD_EVAL, 16'd1, 32'd0, 32'hFFFF_FFFF);
    send_item(CMD_EVAL, index_t'(TERMS - 1), 32'd0, 32'h7FFF_FFFF);
    send_item(CMD_EVAL, 16'd0, 32'd0, 32'h8000_0000);
    send_item(CMD_EVAL, 16'd0, 32'hFFFF_FFFF, 32'd0);
    send_item(CMD_SET, index_t'(TERMS - 1), 32'd0, 32'd0);
    send_item(CMD_SUB, 16'd1, 32'hFFFF_FFFF, 32'd0);
    send_item(CMD_SET, index_t'(TERMS), 32'd0, 32'd0);
    send_item(CMD_ADD, 16'hFFFF, 32'd1, 32'd0);
    send_item(CMD_SUB, index_t'(TERMS), 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(CMD_EVAL, 16'hAAAA, 32'h5555_5555, 32'd3);
    send_item(CMD_SET, index_t'(TERMS - 2), 32'h5555_5555, 32'd0);
    send_item(CMD_SET, 16'd5, 32'hAAAA_AAAA, 32'd0);
    send_item(CMD_ADD, index_t'(TERMS - 2), 32'hAAAA_AAAB, 32'd0);
    send_item(CMD_EVAL, 16'h5555, 32'd0, 32'd2);
    send_item(CMD_SET, 16'd5, 32'd0, 32'd0);
    send_item(CMD_SET, 16'd0, 32'd0, 32'd0);
    send_item(CMD_EVAL, 16'd0, 32'd0, 32'h8000_0000);
  endtask

  // Rebuilds the polynomial at a random degree, mostly small: clears the
  // terms above it from the top down, writes the rest, then evaluates.
  task automatic test_build_and_evaluate(int n);
    int target;
    int top;
    int r;
    target = items_sent + n;
    while (items_sent < target) begin
      r = $urandom_range(99);
      top = (r < 70) ? $urandom_range(7) : (r < 95) ? $urandom_range(8, 31)
                                                    : $urandom_range(32, TERMS - 1);
      for (int k = TERMS - 1; k > top; k--) begin
        if (poly_coef[k] != '0) send_item(CMD_SET, index_t'(k), '0, $urandom);
      end
      for (int k = 0; k <= top; k++) begin
        send_item(($urandom_range(3) == 0) ? pick_cmd(1'b1) : CMD_SET, index_t'(k),
                  rand_word(), $urandom);
      end
      repeat ($urandom_range(1, 3)) send_item(CMD_EVAL, index_t'($urandom), $urandom,
                                              rand_word());
    end
  endtask

  // Whole-polynomial add or subtract, one transfer per coefficient, then an
  // evaluate. Sometimes the current polynomial is subtracted from itself.
  task automatic test_whole_polynomial_ops(int n);
    int   target;
    int   span;
    bit   cancel;
    cmd_t op;
    target = items_sent + n;
    while (items_sent < target) begin
      span = $urandom_range(poly_degree + 2);
      if (span > TERMS - 1) span = TERMS - 1;
      cancel = ($urandom_range(4) == 0);
      op = cancel ? CMD_SUB : (($urandom_range(1) == 0) ? CMD_ADD : CMD_SUB);
      for (int k = 0; k <= span; k++) begin
        send_item(op, index_t'(k), cancel ? poly_coef[k] : rand_word(), $urandom);
      end
      send_item(CMD_EVAL, index_t'($urandom), $urandom, rand_word());
    end
  endtask

  // Single updates, top-term cancels, evaluates, writes beyond the store and
  // fully random commands, mixed item by item.
  task automatic test_random_updates(int n);
    int target;
    int r;
    int hi;
    target = items_sent + n;
    while (items_sent < target) begin
      r = $urandom_range(99);
      hi = poly_degree + 4;
      if (hi > TERMS - 1) hi = TERMS - 1;
      if (r < 35) begin
        send_item(pick_cmd(1'b1), index_t'($urandom_range(hi)), rand_word(), $urandom);
      end else if (r < 45) begin
        send_item(CMD_SUB, index_t'(poly_degree), poly_coef[poly_degree], $urandom);
      end else if (r < 65) begin
        send_item(CMD_EVAL, index_t'($urandom), $urandom, rand_word());
      end else if (r < 80) begin
        send_item(pick_cmd(1'b1), index_t'($urandom_range(TERMS, 16'hFFFF)),
                  ($urandom_range(1) == 0) ? '0 : rand_word(), $urandom);
      end else begin
        send_item(pick_cmd(1'b0), index_t'($urandom), rand_word(), rand_word());
      end
    end
  endtask

  // The sender holds off until every outstanding result has come back.
  task automatic test_drain_pause();
    repeat (4) send_item(pick_cmd(1'b1), index_t'($urandom_range(7)), rand_word(), $urandom);
    send_item(CMD_EVAL, 16'd0, $urandom, rand_word());
    start = 1'b0;
    while (poly_outcomes.size() != 0) @(negedge clk);
    send_item(CMD_EVAL, 16'd0, $urandom, rand_word());
    send_item(pick_cmd(1'b1), index_t'($urandom_range(7)), rand_word(), $urandom);
  endtask

  initial begin : test_sequence
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    test_directed_corners();
    foreach (idle_plan[p]) begin
      idle_pct = idle_plan[p];
      test_build_and_evaluate(300);
      test_whole_polynomial_ops(150);
      test_drain_pause();
      test_random_updates(170);
    end

    // Let the last results arrive, then watch for stray ones.
    start = 1'b0;
    while (poly_outcomes.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d commands (%0d set, %0d add, %0d subtract, %0d evaluate), checked %0d results.",
             items_sent, cmd_counts[CMD_SET], cmd_counts[CMD_ADD], cmd_counts[CMD_SUB],
             cmd_counts[CMD_EVAL], results_seen);
    $display("Out-of-store writes flagged: %0d, degree drops: %0d, top degree: %0d, mismatches: %0d.",
             overflow_hits, degree_drops, max_degree, fail_count);
    if (fail_count == 0 && poly_outcomes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ polynomial_coefficient_store_unit.f @@
hw/rtl/pcs_pkg.sv
hw/rtl/pcs_coeff_ram.sv
hw/rtl/polynomial_coefficient_store_unit.sv
verif/tb_polynomial_coefficient_store_unit.sv
